// ----- design/ddps_pkg.sv -----
// Shared types, constants and helper functions for the differential drive PWM sequencer.
`default_nettype none
package ddps_pkg;

  localparam int DUTY_BITS    = 16;
  localparam int SPEED_BITS   = 17;
  localparam int CFG_BITS     = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int WAIT_BITS    = CFG_BITS + 2;
  localparam int NUM_CHAN     = 8;
  // longest chain of zero-length waits: dwell, half speed step, full speed step
  localparam int SETTLE_STEPS = 3;

  localparam logic [SPEED_BITS-1:0] DUTY_MAX = SPEED_BITS'((1 << DUTY_BITS) - 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_TURN_SPEED = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TURN_TIME  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_DWELL = CFG_IDX_BITS'(2);

  // register reset values
  localparam logic [CFG_BITS-1:0] TURN_SPEED_RST = CFG_BITS'(25);
  localparam logic [CFG_BITS-1:0] TURN_TIME_RST  = CFG_BITS'(150);
  localparam logic [CFG_BITS-1:0] STOP_DWELL_RST = CFG_BITS'(20);

  typedef logic signed [SPEED_BITS-1:0] speed_t;
  typedef logic [DUTY_BITS-1:0]         duty_t;
  typedef logic [WAIT_BITS-1:0]         wait_t;

  typedef enum logic [2:0] {
    CMD_TICK, CMD_MOVE, CMD_STOP, CMD_RIGHT45,
    CMD_LEFT45, CMD_RIGHT90, CMD_LEFT90, CMD_TURN180
  } cmd_code_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_STOP, PH_DW_MOVE, PH_DW_TURN,
    PH_DW_T180, PH_DW_T90, PH_HOLD, PH_T90_FIRST
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK, OP_STOP, OP_START
  } op_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] turn_speed;
    logic [CFG_BITS-1:0] turn_time;
    logic [CFG_BITS-1:0] stop_dwell;
  } cfg_t;

  // decoded command handed from front to back
  typedef struct packed {
    op_t    op;
    phase_t start_phase;
    speed_t first_l;
    speed_t first_r;
    speed_t full_l;
    speed_t full_r;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    wait_t  wait_count;
    speed_t last_l;
    speed_t last_r;
  } settle_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][DUTY_BITS-1:0] duty;
    logic                               busy;
    logic                               rejected;
  } res_t;

  // signed halve, rounding toward zero
  function automatic speed_t half_speed(input speed_t s);
    speed_t adj;
    adj = s + speed_t'({{(SPEED_BITS-1){1'b0}}, s[SPEED_BITS-1]});
    return adj >>> 1;
  endfunction

  // absolute value with saturation to the duty range
  function automatic duty_t magnitude(input speed_t s);
    logic [SPEED_BITS-1:0] m;
    m = s[SPEED_BITS-1] ? SPEED_BITS'(-s) : SPEED_BITS'(s);
    return (m > DUTY_MAX) ? DUTY_MAX[DUTY_BITS-1:0] : m[DUTY_BITS-1:0];
  endfunction

  function automatic logic is_pos(input speed_t s);
    return !s[SPEED_BITS-1] && (s != '0);
  endfunction

  // true when either side would change direction
  function automatic logic flips(input speed_t l, input speed_t r,
                                 input speed_t last_l, input speed_t last_r);
    return (is_pos(l) && last_l[SPEED_BITS-1]) || (l[SPEED_BITS-1] && is_pos(last_l)) ||
           (is_pos(r) && last_r[SPEED_BITS-1]) || (r[SPEED_BITS-1] && is_pos(last_r));
  endfunction

  // run through all waits that are already at zero
  function automatic settle_t settle(input phase_t ph_in, input wait_t w_in,
                                     input speed_t pl, input speed_t pr,
                                     input speed_t ll_in, input speed_t lr_in,
                                     input logic [CFG_BITS-1:0] tt);
    settle_t s;
    s.phase      = ph_in;
    s.wait_count = w_in;
    s.last_l     = ll_in;
    s.last_r     = lr_in;
    for (int i = 0; i < SETTLE_STEPS; i++) begin
      if (s.phase != PH_IDLE && s.wait_count == '0) begin
        case (s.phase)
          PH_DW_MOVE: begin
            s.last_l = pl;
            s.last_r = pr;
            s.phase  = PH_IDLE;
          end
          PH_DW_TURN, PH_T90_FIRST: begin
            s.last_l     = pl;
            s.last_r     = pr;
            s.phase      = PH_HOLD;
            s.wait_count = WAIT_BITS'(tt);
          end
          PH_DW_T180: begin
            s.last_l     = pl;
            s.last_r     = pr;
            s.phase      = PH_HOLD;
            s.wait_count = WAIT_BITS'({tt, 2'b00});
          end
          PH_DW_T90: begin
            s.last_l     = half_speed(pl);
            s.last_r     = half_speed(pr);
            s.phase      = PH_T90_FIRST;
            s.wait_count = WAIT_BITS'(tt);
          end
          default: begin
            s.phase = PH_IDLE;
          end
        endcase
      end
    end
    return s;
  endfunction

  // duty words in channel order from the applied speeds
  function automatic logic [NUM_CHAN-1:0][DUTY_BITS-1:0] duties(input speed_t l,
                                                                input speed_t r);
    logic [NUM_CHAN-1:0][DUTY_BITS-1:0] d;
    duty_t ml;
    duty_t mr;
    ml   = magnitude(l);
    mr   = magnitude(r);
    d[0] = is_pos(l) ? ml : '0;
    d[1] = l[SPEED_BITS-1] ? ml : '0;
    d[2] = is_pos(l) ? ml : '0;
    d[3] = l[SPEED_BITS-1] ? ml : '0;
    d[4] = r[SPEED_BITS-1] ? mr : '0;
    d[5] = is_pos(r) ? mr : '0;
    d[6] = r[SPEED_BITS-1] ? mr : '0;
    d[7] = is_pos(r) ? mr : '0;
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- design/ddps_front.sv -----
// Front end: configuration registers, command decode and a two-entry command queue.
`default_nettype none
module ddps_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // command side
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [2:0]                           cmd,
  input  wire ddps_pkg::speed_t                     left_vel,
  input  wire ddps_pkg::speed_t                     right_vel,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ddps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [ddps_pkg::CFG_BITS-1:0]        cfg_data,
  output ddps_pkg::cfg_t                            cfg,
  // toward the back end
  output logic                                      cmd_valid,
  output ddps_pkg::cmd_t                            cmd_out,
  input  wire logic                                 cmd_take
);

  ddps_pkg::cmd_t    dec;
  ddps_pkg::speed_t  ts;
  ddps_pkg::speed_t  ts_half;
  ddps_pkg::cmd_t    q_mem [2];
  logic              q_wr;
  logic              q_rd;
  logic [1:0]        q_cnt;
  logic              q_push;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_speed <= ddps_pkg::TURN_SPEED_RST;
      cfg.turn_time  <= ddps_pkg::TURN_TIME_RST;
      cfg.stop_dwell <= ddps_pkg::STOP_DWELL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ddps_pkg::REG_TURN_SPEED: cfg.turn_speed <= cfg_data;
        ddps_pkg::REG_TURN_TIME:  cfg.turn_time  <= cfg_data;
        ddps_pkg::REG_STOP_DWELL: cfg.stop_dwell <= cfg_data;
        default: ;
      endcase
    end
  end

  // command decode into speed pairs and starting phase
  assign ts      = ddps_pkg::speed_t'({{(ddps_pkg::SPEED_BITS-ddps_pkg::CFG_BITS){1'b0}},
                                      cfg.turn_speed});
  assign ts_half = ts >>> 1;

  always_comb begin
    dec.op          = ddps_pkg::OP_START;
    dec.start_phase = ddps_pkg::PH_DW_TURN;
    dec.first_l     = ts;
    dec.first_r     = -ts;
    dec.full_l      = ts;
    dec.full_r      = -ts;
    case (ddps_pkg::cmd_code_t'(cmd))
      ddps_pkg::CMD_TICK: begin
        dec.op = ddps_pkg::OP_TICK;
      end
      ddps_pkg::CMD_MOVE: begin
        dec.start_phase = ddps_pkg::PH_DW_MOVE;
        dec.first_l     = left_vel;
        dec.first_r     = right_vel;
        dec.full_l      = left_vel;
        dec.full_r      = right_vel;
      end
      ddps_pkg::CMD_STOP: begin
        dec.op = ddps_pkg::OP_STOP;
      end
      ddps_pkg::CMD_RIGHT45: ;
      ddps_pkg::CMD_LEFT45: begin
        dec.first_l = -ts;
        dec.first_r = ts;
        dec.full_l  = -ts;
        dec.full_r  = ts;
      end
      ddps_pkg::CMD_RIGHT90: begin
        dec.start_phase = ddps_pkg::PH_DW_T90;
        dec.first_l     = ts_half;
        dec.first_r     = -ts_half;
      end
      ddps_pkg::CMD_LEFT90: begin
        dec.start_phase = ddps_pkg::PH_DW_T90;
        dec.first_l     = -ts_half;
        dec.first_r     = ts_half;
        dec.full_l      = -ts;
        dec.full_r      = ts;
      end
      ddps_pkg::CMD_TURN180: begin
        dec.start_phase = ddps_pkg::PH_DW_T180;
        dec.first_l     = -ts;
        dec.first_r     = ts;
        dec.full_l      = -ts;
        dec.full_r      = ts;
      end
      default: ;
    endcase
  end

  // two-entry command queue
  assign full      = (q_cnt == 2'd2);
  assign q_push    = push && !full;
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd_out   = q_mem[q_rd];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (q_push) begin
        q_wr <= ~q_wr;
      end
      if (cmd_take) begin
        q_rd <= ~q_rd;
      end
      q_cnt <= q_cnt + {1'b0, q_push} - {1'b0, cmd_take};
    end
  end

endmodule
`default_nettype wire

// ----- design/ddps_back.sv -----
// Back end: sequencing state, duty word generation and a two-entry result queue.
`default_nettype none
module ddps_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ddps_pkg::cfg_t   cfg,
  input  wire logic             cmd_valid,
  input  wire ddps_pkg::cmd_t   cmd_in,
  output logic                  cmd_take,
  output logic                  empty,
  input  wire logic             pop,
  output ddps_pkg::res_t        res_out
);

  ddps_pkg::phase_t   phase;
  ddps_pkg::wait_t    wait_count;
  ddps_pkg::speed_t   pend_l;
  ddps_pkg::speed_t   pend_r;
  ddps_pkg::speed_t   last_l;
  ddps_pkg::speed_t   last_r;

  ddps_pkg::phase_t   pre_phase;
  ddps_pkg::wait_t    pre_wait;
  ddps_pkg::speed_t   pre_ll;
  ddps_pkg::speed_t   pre_lr;
  ddps_pkg::speed_t   pend_l_next;
  ddps_pkg::speed_t   pend_r_next;
  logic               rej;
  ddps_pkg::settle_t  st;
  ddps_pkg::res_t     res_in;

  ddps_pkg::res_t     r_mem [2];
  logic               r_wr;
  logic               r_rd;
  logic [1:0]         r_cnt;
  logic               r_pop;
  logic               step;

  assign step     = cmd_valid && (r_cnt != 2'd2);
  assign cmd_take = step;

  // one command: tick down, reject, stop, or start a sequence, then settle zero waits
  always_comb begin
    pre_phase   = phase;
    pre_wait    = wait_count;
    pre_ll      = last_l;
    pre_lr      = last_r;
    pend_l_next = pend_l;
    pend_r_next = pend_r;
    rej         = 1'b0;
    if (phase != ddps_pkg::PH_IDLE) begin
      if (cmd_in.op == ddps_pkg::OP_TICK) begin
        if (wait_count != '0) begin
          pre_wait = wait_count - 1'b1;
        end
      end else begin
        rej = 1'b1;
      end
    end else begin
      case (cmd_in.op)
        ddps_pkg::OP_STOP: begin
          pre_ll    = '0;
          pre_lr    = '0;
          pre_phase = ddps_pkg::PH_STOP;
          pre_wait  = ddps_pkg::WAIT_BITS'(cfg.stop_dwell);
        end
        ddps_pkg::OP_START: begin
          pend_l_next = cmd_in.full_l;
          pend_r_next = cmd_in.full_r;
          pre_phase   = cmd_in.start_phase;
          if (ddps_pkg::flips(cmd_in.first_l, cmd_in.first_r, last_l, last_r)) begin
            pre_ll   = '0;
            pre_lr   = '0;
            pre_wait = ddps_pkg::WAIT_BITS'(cfg.stop_dwell);
          end else begin
            pre_wait = '0;
          end
        end
        default: ;
      endcase
    end
    st = ddps_pkg::settle(pre_phase, pre_wait, pend_l_next, pend_r_next,
                          pre_ll, pre_lr, cfg.turn_time);
    res_in.duty     = ddps_pkg::duties(st.last_l, st.last_r);
    res_in.busy     = (st.phase != ddps_pkg::PH_IDLE);
    res_in.rejected = rej;
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ddps_pkg::PH_IDLE;
      wait_count <= '0;
      pend_l     <= '0;
      pend_r     <= '0;
      last_l     <= '0;
      last_r     <= '0;
    end else if (step) begin
      phase      <= st.phase;
      wait_count <= st.wait_count;
      pend_l     <= pend_l_next;
      pend_r     <= pend_r_next;
      last_l     <= st.last_l;
      last_r     <= st.last_r;
    end
  end

  // two-entry result queue
  assign empty   = (r_cnt == 2'd0);
  assign r_pop   = pop && !empty;
  assign res_out = r_mem[r_rd];

  always_ff @(posedge clk) begin
    if (step) begin
      r_mem[r_wr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_wr  <= 1'b0;
      r_rd  <= 1'b0;
      r_cnt <= 2'd0;
    end else begin
      if (step) begin
        r_wr <= ~r_wr;
      end
      if (r_pop) begin
        r_rd <= ~r_rd;
      end
      r_cnt <= r_cnt + {1'b0, step} - {1'b0, r_pop};
    end
  end

  // a running wait never sits at zero once settled
  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase != ddps_pkg::PH_IDLE |-> wait_count != '0)
    else $error("busy phase with zero wait count");

  // a rejection only happens while a sequence runs
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    step && res_in.rejected |-> phase != ddps_pkg::PH_IDLE)
    else $error("command rejected while idle");

  // state moves only on a processed command
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(wait_count) && $stable(last_l) && $stable(last_r))
    else $error("sequencer state changed without a command");

  // result queue never overfills
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    r_cnt != 2'd3)
    else $error("result queue overflow");

  // result busy flag matches the state left behind
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    step |=> r_mem[$past(r_wr)].busy == (phase != ddps_pkg::PH_IDLE))
    else $error("busy flag disagrees with sequencer phase");

endmodule
`default_nettype wire

// ----- design/differential_drive_pwm_sequencer_top.sv -----
// Top level of the differential drive PWM sequencer with brake-before-reverse.
//
// channel   handshake              payload
// command   push / full            cmd, left_vel, right_vel
// result    empty / pop            eight duty words, busy_res, rejected
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command per cycle is sustained while results are popped; each accepted command is
// registered in the command queue, stepped by the back end, and its result registered in
// the result queue, from which it can be popped. All sequencing, including chains of
// zero-length waits, resolves in the single back-end step; a two-entry queue sits on each side of it.
// full rises when two commands wait; the back end holds while two results wait.
// Reset is synchronous; no memory clearing is needed.
`default_nettype none
module differential_drive_pwm_sequencer_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [2:0]                         cmd,
  input  wire logic signed [ddps_pkg::SPEED_BITS-1:0] left_vel,
  input  wire logic signed [ddps_pkg::SPEED_BITS-1:0] right_vel,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [ddps_pkg::DUTY_BITS-1:0]          left_a_fwd,
  output logic [ddps_pkg::DUTY_BITS-1:0]          left_a_rev,
  output logic [ddps_pkg::DUTY_BITS-1:0]          left_b_fwd,
  output logic [ddps_pkg::DUTY_BITS-1:0]          left_b_rev,
  output logic [ddps_pkg::DUTY_BITS-1:0]          right_a_rev,
  output logic [ddps_pkg::DUTY_BITS-1:0]          right_a_fwd,
  output logic [ddps_pkg::DUTY_BITS-1:0]          right_b_rev,
  output logic [ddps_pkg::DUTY_BITS-1:0]          right_b_fwd,
  output logic                                    busy_res,
  output logic                                    rejected,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ddps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ddps_pkg::CFG_BITS-1:0]      cfg_data
);

  ddps_pkg::cfg_t  cfg;
  ddps_pkg::cmd_t  cmd_q;
  logic            cmd_valid;
  logic            cmd_take;
  ddps_pkg::res_t  res;

  // decode and command queue
  ddps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .left_vel    (left_vel),
    .right_vel   (right_vel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .cmd_valid   (cmd_valid),
    .cmd_out     (cmd_q),
    .cmd_take    (cmd_take)
  );

  // sequencer and result queue
  ddps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd_q),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .res_out   (res)
  );

  // result fields onto channel ports
  assign left_a_fwd  = res.duty[0];
  assign left_a_rev  = res.duty[1];
  assign left_b_fwd  = res.duty[2];
  assign left_b_rev  = res.duty[3];
  assign right_a_rev = res.duty[4];
  assign right_a_fwd = res.duty[5];
  assign right_b_rev = res.duty[6];
  assign right_b_fwd = res.duty[7];
  assign busy_res    = res.busy;
  assign rejected    = res.rejected;

endmodule
`default_nettype wire

// ----- dv/differential_drive_pwm_sequencer_top_tb.sv -----
// Self-checking testbench for the differential drive PWM sequencer: queued commands, checked duties.
module differential_drive_pwm_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddps_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_PAUSE  = 6;
  localparam int DUTY_CEIL    = (1 << DUTY_BITS) - 1;
  // index past the end of the register list, writes to it are dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

  typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

  typedef struct {
    cmd_code_t cmd;
    speed_t    l_speed;
    speed_t    r_speed;
    bit        drain_first;
  } cmd_item_t;

  // DUT signals, all inputs known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [2:0] cmd = '0;
  speed_t left_vel = '0;
  speed_t right_vel = '0;
  logic empty;
  logic pop = 1'b0;
  duty_t left_a_fwd, left_a_rev, left_b_fwd, left_b_rev;
  duty_t right_a_rev, right_a_fwd, right_b_rev, right_b_fwd;
  logic busy_res;
  logic rejected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  differential_drive_pwm_sequencer_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .left_vel    (left_vel),
    .right_vel   (right_vel),
    .empty       (empty),
    .pop         (pop),
    .left_a_fwd  (left_a_fwd),
    .left_a_rev  (left_a_rev),
    .left_b_fwd  (left_b_fwd),
    .left_b_rev  (left_b_rev),
    .right_a_rev (right_a_rev),
    .right_a_fwd (right_a_fwd),
    .right_b_rev (right_b_rev),
    .right_b_fwd (right_b_fwd),
    .busy_res    (busy_res),
    .rejected    (rejected),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // testbench bookkeeping
  cmd_item_t cmd_q[$];
  res_t      duty_expect_q[$];
  cmd_item_t in_flight;
  gap_mode_t gap_mode = GAP_NONE;
  int        n_accepted = 0;
  int        n_checked = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        fill_count = 0;
  bit        hold_next = 1'b0;
  res_t      want;
  duty_t     seen_duty [NUM_CHAN];
  string     chan_name [NUM_CHAN] = '{"left_a_fwd", "left_a_rev", "left_b_fwd", "left_b_rev",
                                      "right_a_rev", "right_a_fwd", "right_b_rev",
                                      "right_b_fwd"};

  // predictor state
  phase_t              mdl_phase;
  wait_t               mdl_wait;
  speed_t              mdl_last_l, mdl_last_r;
  speed_t              mdl_pend_l, mdl_pend_r;
  logic [CFG_BITS-1:0] mdl_ts, mdl_tt, mdl_sd;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void mdl_reset();
    mdl_ts     = TURN_SPEED_RST;
    mdl_tt     = TURN_TIME_RST;
    mdl_sd     = STOP_DWELL_RST;
    mdl_phase  = PH_IDLE;
    mdl_wait   = '0;
    mdl_last_l = '0;
    mdl_last_r = '0;
    mdl_pend_l = '0;
    mdl_pend_r = '0;
  endfunction

  function automatic duty_t sat_mag(input speed_t s);
    int m;
    m = (s < 0) ? -int'(s) : int'(s);
    return (m > DUTY_CEIL) ? duty_t'(DUTY_CEIL) : duty_t'(m);
  endfunction

  // duties always follow the last applied speeds
  function automatic void apply_speeds(input speed_t l, input speed_t r);
    mdl_last_l = l;
    mdl_last_r = r;
  endfunction

  function automatic void clear_drive();
    apply_speeds('0, '0);
  endfunction

  function automatic void step_phase();
    case (mdl_phase)
      PH_DW_MOVE: begin
        apply_speeds(mdl_pend_l, mdl_pend_r);
        mdl_phase = PH_IDLE;
      end
      PH_DW_TURN, PH_T90_FIRST: begin
        apply_speeds(mdl_pend_l, mdl_pend_r);
        mdl_phase = PH_HOLD;
        mdl_wait  = wait_t'(mdl_tt);
      end
      PH_DW_T180: begin
        apply_speeds(mdl_pend_l, mdl_pend_r);
        mdl_phase = PH_HOLD;
        mdl_wait  = wait_t'(wait_t'(mdl_tt) * 4);
      end
      PH_DW_T90: begin
        apply_speeds(speed_t'(mdl_pend_l / 2), speed_t'(mdl_pend_r / 2));
        mdl_phase = PH_T90_FIRST;
        mdl_wait  = wait_t'(mdl_tt);
      end
      default: mdl_phase = PH_IDLE;
    endcase
  endfunction

  // zero-length waits finish within the same command
  function automatic void run_settle();
    while (mdl_phase != PH_IDLE && mdl_wait == '0)
      step_phase();
  endfunction

  function automatic bit would_flip(input speed_t l, input speed_t r);
    return (l > 0 && mdl_last_l < 0) || (l < 0 && mdl_last_l > 0) ||
           (r > 0 && mdl_last_r < 0) || (r < 0 && mdl_last_r > 0);
  endfunction

  function automatic void launch(input speed_t first_l, input speed_t first_r,
                                 input speed_t full_l, input speed_t full_r, input phase_t ph);
    mdl_pend_l = full_l;
    mdl_pend_r = full_r;
    mdl_phase  = ph;
    if (would_flip(first_l, first_r)) begin
      clear_drive();
      mdl_wait = wait_t'(mdl_sd);
    end else begin
      mdl_wait = '0;
    end
    run_settle();
  endfunction

  // next duty words, busy and reject flag for one command
  function automatic res_t predict_duties(input cmd_item_t it);
    res_t   r;
    speed_t ts;
    speed_t th;
    duty_t  ml, mr;
    logic   rej;
    ts  = speed_t'({1'b0, mdl_ts});
    th  = speed_t'(ts / 2);
    rej = 1'b0;
    if (mdl_phase != PH_IDLE) begin
      if (it.cmd == CMD_TICK) begin
        if (mdl_wait != '0) mdl_wait = mdl_wait - 1'b1;
        run_settle();
      end else begin
        rej = 1'b1;
      end
    end else begin
      case (it.cmd)
        CMD_MOVE:    launch(it.l_speed, it.r_speed, it.l_speed, it.r_speed, PH_DW_MOVE);
        CMD_STOP: begin
          clear_drive();
          mdl_phase = PH_STOP;
          mdl_wait  = wait_t'(mdl_sd);
          run_settle();
        end
        CMD_RIGHT45: launch(ts, -ts, ts, -ts, PH_DW_TURN);
        CMD_LEFT45:  launch(-ts, ts, -ts, ts, PH_DW_TURN);
        CMD_RIGHT90: launch(th, -th, ts, -ts, PH_DW_T90);
        CMD_LEFT90:  launch(-th, th, -ts, ts, PH_DW_T90);
        CMD_TURN180: launch(-ts, ts, -ts, ts, PH_DW_T180);
        default: ;
      endcase
    end
    ml = sat_mag(mdl_last_l);
    mr = sat_mag(mdl_last_r);
    r.duty[0]   = (mdl_last_l > 0) ? ml : '0;
    r.duty[1]   = (mdl_last_l < 0) ? ml : '0;
    r.duty[2]   = (mdl_last_l > 0) ? ml : '0;
    r.duty[3]   = (mdl_last_l < 0) ? ml : '0;
    r.duty[4]   = (mdl_last_r < 0) ? mr : '0;
    r.duty[5]   = (mdl_last_r > 0) ? mr : '0;
    r.duty[6]   = (mdl_last_r < 0) ? mr : '0;
    r.duty[7]   = (mdl_last_r > 0) ? mr : '0;
    r.busy      = (mdl_phase != PH_IDLE);
    r.rejected  = rej;
    return r;
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_pct();
    case (gap_mode)
      GAP_SEND: return 80;
      GAP_BOTH: return 15;
      default:  return 0;
    endcase
  endfunction

  function automatic int recv_pct();
    case (gap_mode)
      GAP_RECV: return 80;
      GAP_BOTH: return 15;
      default:  return 0;
    endcase
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        duty_expect_q.push_back(predict_duties(in_flight));
        n_accepted++;
      end
      if (!push || !full) begin
        if (cmd_q.size() > 0 && !(cmd_q[0].drain_first && n_accepted != n_checked) &&
            !roll(send_pct())) begin
          in_flight = cmd_q.pop_front();
          push      <= 1'b1;
          cmd       <= in_flight.cmd;
          left_vel  <= in_flight.l_speed;
          right_vel <= in_flight.r_speed;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked <= n_checked + 1;
        if (duty_expect_q.size() == 0) begin
          report_mismatch("result transaction with no pending expectation");
        end else begin
          want = duty_expect_q.pop_front();
          seen_duty[0] = left_a_fwd;
          seen_duty[1] = left_a_rev;
          seen_duty[2] = left_b_fwd;
          seen_duty[3] = left_b_rev;
          seen_duty[4] = right_a_rev;
          seen_duty[5] = right_a_fwd;
          seen_duty[6] = right_b_rev;
          seen_duty[7] = right_b_fwd;
          for (int i = 0; i < NUM_CHAN; i++) begin
            if (seen_duty[i] !== want.duty[i])
              report_mismatch($sformatf("result %0d %s got %0d want %0d", n_checked,
                                        chan_name[i], seen_duty[i], want.duty[i]));
          end
          if (busy_res !== want.busy)
            report_mismatch($sformatf("result %0d busy_res got %b want %b", n_checked,
                                      busy_res, want.busy));
          if (rejected !== want.rejected)
            report_mismatch($sformatf("result %0d rejected got %b want %b", n_checked,
                                      rejected, want.rejected));
        end
      end
      pop <= !roll(recv_pct());
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TURN_SPEED: mdl_ts = val;
      REG_TURN_TIME:  mdl_tt = val;
      REG_STOP_DWELL: mdl_sd = val;
      default: ;
    endcase
  endtask

  // wait until every transaction is back, then let the pipeline go quiet
  task automatic wait_drained();
    do @(negedge clk); while (cmd_q.size() != 0 || push || n_accepted != n_checked);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  function automatic void add_item(input cmd_code_t c, input speed_t l, input speed_t r);
    cmd_item_t it;
    it.cmd         = c;
    it.l_speed     = l;
    it.r_speed     = r;
    it.drain_first = hold_next;
    hold_next      = 1'b0;
    cmd_q.push_back(it);
    fill_count++;
  endfunction

  function automatic speed_t rand_speed();
    speed_t s;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 5))
          0:       s = 65535;
          1:       s = -65535;
          2:       s = -65536;
          3:       s = 0;
          4:       s = 1;
          default: s = -1;
        endcase
      end
      1, 2:    s = speed_t'($urandom);
      default: s = speed_t'(int'($urandom_range(0, 600)) - 300);
    endcase
    return s;
  endfunction

  function automatic void add_tick();
    add_item(CMD_TICK, rand_speed(), rand_speed());
  endfunction

  // one command, then mostly enough ticks to run out its waits
  function automatic void add_sequence(input int tt, input int sd);
    cmd_code_t c;
    int        bound;
    int        k;
    c = cmd_code_t'($urandom_range(1, 7));
    add_item(c, rand_speed(), rand_speed());
    case (c)
      CMD_RIGHT45, CMD_LEFT45: bound = sd + tt;
      CMD_RIGHT90, CMD_LEFT90: bound = sd + 2 * tt;
      CMD_TURN180:             bound = sd + 4 * tt;
      default:                 bound = sd;
    endcase
    case ($urandom_range(0, 9))
      0: add_item(cmd_code_t'($urandom_range(0, 7)), rand_speed(), rand_speed());
      1: begin
        // command dropped into the middle of a wait
        k = $urandom_range(0, bound);
        repeat (k) add_tick();
        add_item(cmd_code_t'($urandom_range(1, 7)), rand_speed(), rand_speed());
        repeat (bound - k + 1) add_tick();
      end
      default: repeat (bound + $urandom_range(0, 1)) add_tick();
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_BITS-1:0] ts, input logic [CFG_BITS-1:0] tt,
                           input logic [CFG_BITS-1:0] sd, input gap_mode_t mode,
                           input int target);
    bit marked;
    write_reg(REG_TURN_SPEED, ts);
    write_reg(REG_TURN_TIME, tt);
    write_reg(REG_STOP_DWELL, sd);
    @(negedge clk);
    gap_mode   = mode;
    fill_count = 0;
    marked     = 1'b0;
    while (fill_count < target) begin
      // one hold-off in the middle: sender waits for all results
      if (!marked && fill_count >= target / 2) begin
        hold_next = 1'b1;
        marked    = 1'b1;
      end
      add_sequence(tt, sd);
    end
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    mdl_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: register reset values, saturation, reversal brake, busy reject
    @(negedge clk);
    gap_mode = GAP_NONE;
    add_item(CMD_TICK, 0, 0);
    add_item(CMD_MOVE, 65535, -65536);
    add_item(CMD_MOVE, -1, 1);
    add_item(CMD_STOP, 0, 0);
    repeat (20) add_item(CMD_TICK, 0, 0);
    wait_drained();

    // directed: zero-length dwell and hold chains at full turn speed
    write_reg(REG_TURN_SPEED, 8'hFF);
    write_reg(REG_TURN_TIME, 8'h00);
    write_reg(REG_STOP_DWELL, 8'h00);
    write_reg(REG_SPARE, 8'hFF);
    @(negedge clk);
    add_item(CMD_RIGHT45, 0, 0);
    add_item(CMD_LEFT90, 0, 0);
    add_item(CMD_TURN180, 0, 0);
    add_item(CMD_STOP, 0, 0);
    add_item(CMD_MOVE, 0, 0);
    add_item(CMD_RIGHT90, -65536, 65535);
    wait_drained();

    // random phases across settings and idling patterns
    run_phase(8'h00, CFG_BITS'($urandom_range(1, 4)), CFG_BITS'($urandom_range(0, 3)),
              GAP_NONE, 130);
    run_phase(8'hFF, 8'h00, 8'h00, GAP_SEND, 130);
    run_phase(CFG_BITS'($urandom_range(0, 255)), CFG_BITS'($urandom_range(0, 5)),
              CFG_BITS'($urandom_range(0, 5)), GAP_RECV, 130);
    run_phase(CFG_BITS'($urandom_range(0, 255)), CFG_BITS'($urandom_range(0, 5)),
              CFG_BITS'($urandom_range(0, 5)), GAP_BOTH, 130);

    // longest dwell and longest single-step hold
    write_reg(REG_TURN_SPEED, 8'hFF);
    write_reg(REG_TURN_TIME, 8'hFF);
    write_reg(REG_STOP_DWELL, 8'hFF);
    @(negedge clk);
    gap_mode = GAP_NONE;
    add_item(CMD_STOP, 0, 0);
    add_item(CMD_MOVE, 100, 100);
    repeat (256) add_tick();
    add_item(CMD_RIGHT45, 0, 0);
    add_item(CMD_TURN180, 0, 0);
    repeat (256) add_tick();
    wait_drained();

    if (duty_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expectations left over", duty_expect_q.size()));
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
